>>> rtl/pqe_pkg.sv
// shared constants for the primitive quad expander
package pqe_pkg;

    localparam int INDEX_BITS_DEF = 16;
    localparam int COORD_BITS_DEF = 16;

    localparam logic [31:0] ALPHA_MASK = 32'hFF00_0000;

    localparam logic [2:0] CMD_LINE       = 3'd0;
    localparam logic [2:0] CMD_RECT_LINE  = 3'd1;
    localparam logic [2:0] CMD_RECT_FILL  = 3'd2;
    localparam logic [2:0] CMD_QUAD_LINE  = 3'd3;
    localparam logic [2:0] CMD_QUAD_FILL  = 3'd4;

    localparam logic KIND_VERTEX = 1'b0;
    localparam logic KIND_INDEX  = 1'b1;

endpackage

>>> rtl/pqe_cmd_if.sv
// request channel carrying one drawing command
interface pqe_cmd_if;
    logic               valid;
    logic               ready;
    logic [2:0]         cmd;
    logic signed [15:0] p1_x;
    logic signed [15:0] p1_y;
    logic signed [15:0] p2_x;
    logic signed [15:0] p2_y;
    logic signed [15:0] p3_x;
    logic signed [15:0] p3_y;
    logic signed [15:0] p4_x;
    logic signed [15:0] p4_y;
    logic [31:0]        color;
    logic [11:0]        thickness;

    modport source (output valid, cmd, p1_x, p1_y, p2_x, p2_y, p3_x, p3_y, p4_x, p4_y,
                    color, thickness, input ready);
    modport sink   (input valid, cmd, p1_x, p1_y, p2_x, p2_y, p3_x, p3_y, p4_x, p4_y,
                    color, thickness, output ready);
endinterface

>>> rtl/pqe_res_if.sv
// result channel carrying vertices and indices
interface pqe_res_if;
    logic               valid;
    logic               ready;
    logic               kind;
    logic signed [15:0] vx;
    logic signed [15:0] vy;
    logic [31:0]        vcolor;
    logic [15:0]        index_value;
    logic               last;

    modport source (output valid, kind, vx, vy, vcolor, index_value, last, input ready);
    modport sink   (input valid, kind, vx, vy, vcolor, index_value, last, output ready);
endinterface

>>> rtl/primitive_quad_expander.sv
// primitive quad expander: thick lines, rectangles and quads to vertices and indices
// One command is taken while the block is idle; every drawn quad then gives four vertex
// results and six index results, the indices counted from a base that advances by four
// per quad and wraps at INDEX_BITS. A fill picks its quad and forms the corners. Each drawn
// edge of a line or outline first picks the edge, then takes the squared length, the
// bit-serial division of 2^62 by it, the bit-serial square root and the offset products
// on the one shared multiplier, and forms the corners; its ten results then go out at
// one result per cycle while the sink is ready.
// Zero alpha, an unknown command or an outline with all edges of zero length gives nothing
// and the block stays ready.
module primitive_quad_expander #(
    parameter int INDEX_BITS = pqe_pkg::INDEX_BITS_DEF,
    parameter int COORD_BITS = pqe_pkg::COORD_BITS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    pqe_cmd_if.sink    cmd_ch,
    pqe_res_if.source  res_ch
);
    import pqe_pkg::*;

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_SEL  = 4'd1;
    localparam logic [3:0] ST_LEN1 = 4'd2;
    localparam logic [3:0] ST_LEN2 = 4'd3;
    localparam logic [3:0] ST_DIV  = 4'd4;
    localparam logic [3:0] ST_SQRT = 4'd5;
    localparam logic [3:0] ST_MY1  = 4'd6;
    localparam logic [3:0] ST_MY2  = 4'd7;
    localparam logic [3:0] ST_MX1  = 4'd8;
    localparam logic [3:0] ST_MX2  = 4'd9;
    localparam logic [3:0] ST_VTX  = 4'd10;
    localparam logic [3:0] ST_EMIT = 4'd11;

    localparam logic signed [32:0] SAT_HI = (33'sd1 <<< (COORD_BITS - 1)) - 33'sd1;
    localparam logic signed [32:0] SAT_LO = -SAT_HI - 33'sd1;

    function automatic logic [15:0] sat_coord(input logic signed [17:0] v);
        logic signed [32:0] w;
        begin
            w = 33'(v);
            if (w > SAT_HI)
                w = SAT_HI;
            else if (w < SAT_LO)
                w = SAT_LO;
            return w[15:0];
        end
    endfunction

    logic [3:0]            state_reg, state_next;
    logic signed [15:0]    px_reg [4];
    logic signed [15:0]    py_reg [4];
    logic signed [15:0]    px_next [4];
    logic signed [15:0]    py_next [4];
    logic [3:0]            mask_reg, mask_next;
    logic                  fill_reg, fill_next;
    logic [31:0]           color_reg, color_next;
    logic [11:0]           thick_reg, thick_next;
    logic [1:0]            edge_reg, edge_next;
    logic [5:0]            step_reg, step_next;
    logic [33:0]           len_reg, len_next;
    logic [35:0]           rem_reg, rem_next;
    logic [63:0]           quo_reg, quo_next;
    logic [31:0]           root_reg, root_next;
    logic [28:0]           pt_reg, pt_next;
    logic signed [15:0]    ox_reg, ox_next;
    logic signed [15:0]    oy_reg, oy_next;
    logic [15:0]           vtx_x_reg [4];
    logic [15:0]           vtx_y_reg [4];
    logic [15:0]           vtx_x_next [4];
    logic [15:0]           vtx_y_next [4];
    logic [3:0]            k_reg, k_next;
    logic [INDEX_BITS-1:0] cnt_reg, cnt_next;

    logic                  ov_reg, ov_next;
    logic                  kind_reg, kind_next;
    logic [15:0]           vx_reg, vx_next;
    logic [15:0]           vy_reg, vy_next;
    logic [31:0]           vcol_reg, vcol_next;
    logic [15:0]           idx_reg, idx_next;
    logic                  last_reg, last_next;

    // corners of the incoming command
    logic signed [15:0]    cx [4];
    logic signed [15:0]    cy [4];
    logic [3:0]            nz;
    logic [3:0]            in_mask;
    logic                  is_rect;
    logic                  accept;

    // current edge
    logic [1:0]            e1;
    logic signed [16:0]    dx, dy;
    logic [16:0]           adx, ady;

    // shared multiplier and subtractor
    logic [28:0]           mul_a;
    logic [31:0]           mul_b;
    logic [60:0]           prod;
    logic [61:0]           rnd;
    logic [13:0]           omag;
    logic [35:0]           sub_a, sub_b;
    logic [36:0]           diff;
    logic                  ge;
    logic [35:0]           div_sh, sq_sh;

    logic [3:0]            above;
    logic [1:0]            ord;
    logic [INDEX_BITS-1:0] idx_full;

    assign accept = cmd_ch.valid && cmd_ch.ready;
    assign cmd_ch.ready = (state_reg == ST_IDLE);

    always_comb
    begin
        is_rect = (cmd_ch.cmd == CMD_RECT_LINE) || (cmd_ch.cmd == CMD_RECT_FILL);
        cx[0] = cmd_ch.p1_x;
        cy[0] = cmd_ch.p1_y;
        cx[1] = cmd_ch.p2_x;
        cy[1] = is_rect ? cmd_ch.p1_y : cmd_ch.p2_y;
        cx[2] = is_rect ? cmd_ch.p2_x : cmd_ch.p3_x;
        cy[2] = is_rect ? cmd_ch.p2_y : cmd_ch.p3_y;
        cx[3] = is_rect ? cmd_ch.p1_x : cmd_ch.p4_x;
        cy[3] = is_rect ? cmd_ch.p2_y : cmd_ch.p4_y;
        for (int i = 0; i < 4; i++)
            nz[i] = (cx[i] != cx[(i + 1) % 4]) || (cy[i] != cy[(i + 1) % 4]);
        case (cmd_ch.cmd)
            CMD_LINE:      in_mask = {3'b000, nz[0]};
            CMD_RECT_LINE: in_mask = nz;
            CMD_QUAD_LINE: in_mask = nz;
            CMD_RECT_FILL: in_mask = 4'b0001;
            CMD_QUAD_FILL: in_mask = 4'b0001;
            default:       in_mask = 4'b0000;
        endcase
        if ((cmd_ch.color & ALPHA_MASK) == 32'd0)
            in_mask = 4'b0000;
    end

    always_comb
    begin
        e1  = edge_reg + 2'd1;
        dx  = 17'(px_reg[e1]) - 17'(px_reg[edge_reg]);
        dy  = 17'(py_reg[e1]) - 17'(py_reg[edge_reg]);
        adx = dx[16] ? 17'(-dx) : 17'(dx);
        ady = dy[16] ? 17'(-dy) : 17'(dy);

        case (state_reg)
            ST_LEN1:
            begin
                mul_a = 29'(adx);
                mul_b = 32'(adx);
            end
            ST_LEN2:
            begin
                mul_a = 29'(ady);
                mul_b = 32'(ady);
            end
            ST_MY1:
            begin
                mul_a = 29'(ady);
                mul_b = 32'(thick_reg);
            end
            ST_MX1:
            begin
                mul_a = 29'(adx);
                mul_b = 32'(thick_reg);
            end
            default:
            begin
                mul_a = pt_reg;
                mul_b = root_reg;
            end
        endcase
        prod = 61'(mul_a) * 61'(mul_b);
        rnd  = {1'b0, prod} + (62'd1 << 31);
        omag = rnd[45:32];

        div_sh = {rem_reg[34:0], (step_reg == 6'd0)};
        sq_sh  = {rem_reg[33:0], quo_reg[63:62]};
        if (state_reg == ST_DIV)
        begin
            sub_a = div_sh;
            sub_b = {2'b00, len_reg};
        end
        else
        begin
            sub_a = sq_sh;
            sub_b = {2'b00, root_reg, 2'b01};
        end
        diff = {1'b0, sub_a} - {1'b0, sub_b};
        ge   = !diff[36];

        for (int i = 0; i < 4; i++)
            above[i] = mask_reg[i] && (i > int'(edge_reg));
        case (k_reg)
            4'd4:    ord = 2'd0;
            4'd5:    ord = 2'd1;
            4'd6:    ord = 2'd2;
            4'd7:    ord = 2'd0;
            4'd8:    ord = 2'd2;
            default: ord = 2'd3;
        endcase
        idx_full = cnt_reg + INDEX_BITS'(ord);
    end

    always_comb
    begin
        state_next = state_reg;
        px_next    = px_reg;
        py_next    = py_reg;
        mask_next  = mask_reg;
        fill_next  = fill_reg;
        color_next = color_reg;
        thick_next = thick_reg;
        edge_next  = edge_reg;
        step_next  = step_reg;
        len_next   = len_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        root_next  = root_reg;
        pt_next    = pt_reg;
        ox_next    = ox_reg;
        oy_next    = oy_reg;
        vtx_x_next = vtx_x_reg;
        vtx_y_next = vtx_y_reg;
        k_next     = k_reg;
        cnt_next   = cnt_reg;
        ov_next    = ov_reg && !res_ch.ready;
        kind_next  = kind_reg;
        vx_next    = vx_reg;
        vy_next    = vy_reg;
        vcol_next  = vcol_reg;
        idx_next   = idx_reg;
        last_next  = last_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept && (in_mask != 4'b0000))
                begin
                    px_next    = cx;
                    py_next    = cy;
                    mask_next  = in_mask;
                    fill_next  = (cmd_ch.cmd == CMD_RECT_FILL) ||
                                 (cmd_ch.cmd == CMD_QUAD_FILL);
                    color_next = cmd_ch.color;
                    thick_next = cmd_ch.thickness;
                    edge_next  = 2'd0;
                    state_next = ST_SEL;
                end
            end
            ST_SEL:
            begin
                if (mask_reg[edge_reg])
                begin
                    if (fill_reg)
                    begin
                        ox_next    = 16'sd0;
                        oy_next    = 16'sd0;
                        state_next = ST_VTX;
                    end
                    else
                        state_next = ST_LEN1;
                end
                else
                    edge_next = edge_reg + 2'd1;
            end
            ST_LEN1:
            begin
                len_next   = prod[33:0];
                state_next = ST_LEN2;
            end
            ST_LEN2:
            begin
                len_next   = len_reg + prod[33:0];
                rem_next   = '0;
                quo_next   = '0;
                step_next  = 6'd0;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                // restoring division of 2^62 by the squared length
                rem_next  = ge ? diff[35:0] : div_sh;
                quo_next  = {quo_reg[62:0], ge};
                step_next = step_reg + 6'd1;
                if (step_reg == 6'd62)
                begin
                    step_next  = 6'd0;
                    rem_next   = '0;
                    root_next  = '0;
                    state_next = ST_SQRT;
                end
            end
            ST_SQRT:
            begin
                // two radicand bits per step, one root bit out
                rem_next  = ge ? diff[35:0] : sq_sh;
                root_next = {root_reg[30:0], ge};
                quo_next  = {quo_reg[61:0], 2'b00};
                step_next = step_reg + 6'd1;
                if (step_reg == 6'd31)
                    state_next = ST_MY1;
            end
            ST_MY1:
            begin
                pt_next    = prod[28:0];
                state_next = ST_MY2;
            end
            ST_MY2:
            begin
                // x offset points against the sign of dy
                ox_next    = dy[16] ? 16'(omag) : -16'(omag);
                state_next = ST_MX1;
            end
            ST_MX1:
            begin
                pt_next    = prod[28:0];
                state_next = ST_MX2;
            end
            ST_MX2:
            begin
                oy_next    = dx[16] ? -16'(omag) : 16'(omag);
                state_next = ST_VTX;
            end
            ST_VTX:
            begin
                if (fill_reg)
                begin
                    for (int i = 0; i < 4; i++)
                    begin
                        vtx_x_next[i] = sat_coord(18'(px_reg[i]));
                        vtx_y_next[i] = sat_coord(18'(py_reg[i]));
                    end
                end
                else
                begin
                    vtx_x_next[0] = sat_coord(18'(px_reg[edge_reg]) + 18'(ox_reg));
                    vtx_y_next[0] = sat_coord(18'(py_reg[edge_reg]) + 18'(oy_reg));
                    vtx_x_next[1] = sat_coord(18'(px_reg[e1]) + 18'(ox_reg));
                    vtx_y_next[1] = sat_coord(18'(py_reg[e1]) + 18'(oy_reg));
                    vtx_x_next[2] = sat_coord(18'(px_reg[e1]) - 18'(ox_reg));
                    vtx_y_next[2] = sat_coord(18'(py_reg[e1]) - 18'(oy_reg));
                    vtx_x_next[3] = sat_coord(18'(px_reg[edge_reg]) - 18'(ox_reg));
                    vtx_y_next[3] = sat_coord(18'(py_reg[edge_reg]) - 18'(oy_reg));
                end
                k_next     = 4'd0;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (!ov_reg || res_ch.ready)
                begin
                    ov_next = 1'b1;
                    if (k_reg < 4'd4)
                    begin
                        kind_next = KIND_VERTEX;
                        vx_next   = vtx_x_reg[k_reg[1:0]];
                        vy_next   = vtx_y_reg[k_reg[1:0]];
                        vcol_next = color_reg;
                        idx_next  = 16'd0;
                    end
                    else
                    begin
                        kind_next = KIND_INDEX;
                        vx_next   = 16'd0;
                        vy_next   = 16'd0;
                        vcol_next = 32'd0;
                        idx_next  = idx_full[15:0];
                    end
                    last_next = (k_reg == 4'd9) && (above == 4'b0000);
                    k_next    = k_reg + 4'd1;
                    if (k_reg == 4'd9)
                    begin
                        cnt_next = cnt_reg + INDEX_BITS'(4);
                        if (above == 4'b0000)
                            state_next = ST_IDLE;
                        else
                        begin
                            edge_next  = edge_reg + 2'd1;
                            state_next = ST_SEL;
                        end
                    end
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        px_reg    <= px_next;
        py_reg    <= py_next;
        mask_reg  <= mask_next;
        fill_reg  <= fill_next;
        color_reg <= color_next;
        thick_reg <= thick_next;
        edge_reg  <= edge_next;
        step_reg  <= step_next;
        len_reg   <= len_next;
        rem_reg   <= rem_next;
        quo_reg   <= quo_next;
        root_reg  <= root_next;
        pt_reg    <= pt_next;
        ox_reg    <= ox_next;
        oy_reg    <= oy_next;
        vtx_x_reg <= vtx_x_next;
        vtx_y_reg <= vtx_y_next;
        k_reg     <= k_next;
        kind_reg  <= kind_next;
        vx_reg    <= vx_next;
        vy_reg    <= vy_next;
        vcol_reg  <= vcol_next;
        idx_reg   <= idx_next;
        last_reg  <= last_next;
    end

    assign res_ch.valid       = ov_reg;
    assign res_ch.kind        = kind_reg;
    assign res_ch.vx          = vx_reg;
    assign res_ch.vy          = vy_reg;
    assign res_ch.vcolor      = vcol_reg;
    assign res_ch.index_value = idx_reg;
    assign res_ch.last        = last_reg;

    a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg != $past(cnt_reg)) |-> (cnt_reg == $past(cnt_reg) + INDEX_BITS'(4)))
        else $error("base vertex moved by other than four");

    a_index_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (res_ch.valid && (res_ch.kind == KIND_INDEX)) |->
        (res_ch.vx == 16'd0 && res_ch.vy == 16'd0 && res_ch.vcolor == 32'd0))
        else $error("index result carries vertex data");

    a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
        (res_ch.valid && res_ch.last) |-> (res_ch.kind == KIND_INDEX))
        else $error("final result is not an index");

    a_load_emit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_ch.valid) |-> ($past(state_reg) == ST_EMIT))
        else $error("result loaded outside emit");

endmodule

>>> test/tb.sv
// testbench for the primitive quad expander: directed and random commands against a predictor
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import pqe_pkg::*;

    typedef struct {
        logic [2:0]         cmd;
        logic signed [15:0] px [4];
        logic signed [15:0] py [4];
        logic [31:0]        color;
        logic [11:0]        thickness;
    } draw_cmd_t;

    typedef struct {
        logic               kind;
        logic signed [15:0] vx;
        logic signed [15:0] vy;
        logic [31:0]        vcolor;
        logic [15:0]        index_value;
        logic               last;
    } geom_res_t;

    class quad_scoreboard;
        geom_res_t   pending[$];
        logic [15:0] base_vertex;
        int          errors;

        function new();
            base_vertex = '0;
            errors = 0;
        endfunction

        function logic [15:0] sat16(longint v);
            if (v > 32767) return 16'sd32767;
            if (v < -32768) return 16'h8000;
            return v[15:0];
        endfunction

        function void push_quad(longint xs[4], longint ys[4], logic [31:0] col);
            geom_res_t r;
            int ord[6] = '{0, 1, 2, 0, 2, 3};
            for (int k = 0; k < 4; k++)
            begin
                r = '{KIND_VERTEX, sat16(xs[k]), sat16(ys[k]), col, 16'd0, 1'b0};
                pending.insert(pending.size(), r);
            end
            for (int k = 0; k < 6; k++)
            begin
                r = '{KIND_INDEX, 16'sd0, 16'sd0, 32'd0, base_vertex + 16'(ord[k]), 1'b0};
                pending.insert(pending.size(), r);
            end
            base_vertex = base_vertex + 16'd4;
        endfunction

        function longint offset_part(longint comp, longint t, longint r, bit negate);
            longint unsigned mag, o;
            bit neg;
            mag = comp < 0 ? -comp : comp;
            o = (mag * t * r + 64'h8000_0000) >> 32;
            neg = (comp < 0) != negate;
            return neg ? -longint'(o) : longint'(o);
        endfunction

        function void push_line(longint ax, longint ay, longint bx, longint by,
                                longint t, logic [31:0] col);
            longint dx, dy, ox, oy;
            longint unsigned len2, y, q, c;
            longint xs[4], ys[4];
            dx = bx - ax;
            dy = by - ay;
            len2 = dx * dx + dy * dy;
            if (len2 == 0) return;
            y = (64'd1 << 62) / len2;
            q = 0;
            for (int b = 31; b >= 0; b--)
            begin
                c = q | (64'd1 << b);
                if (c * c <= y) q = c;
            end
            ox = offset_part(dy, t, q, 1'b1);
            oy = offset_part(dx, t, q, 1'b0);
            xs = '{ax + ox, bx + ox, bx - ox, ax - ox};
            ys = '{ay + oy, by + oy, by - oy, ay - oy};
            push_quad(xs, ys, col);
        endfunction

        function void note_cmd(draw_cmd_t d);
            longint xs[4], ys[4];
            int prior_size;
            prior_size = pending.size();
            for (int i = 0; i < 4; i++)
            begin
                xs[i] = d.px[i];
                ys[i] = d.py[i];
            end
            if ((d.color & ALPHA_MASK) == 0 || d.cmd > CMD_QUAD_FILL) return;
            if (d.cmd == CMD_RECT_LINE || d.cmd == CMD_RECT_FILL)
            begin
                xs[1] = d.px[1]; ys[1] = d.py[0];
                xs[2] = d.px[1]; ys[2] = d.py[1];
                xs[3] = d.px[0]; ys[3] = d.py[1];
            end
            if (d.cmd == CMD_LINE)
                push_line(xs[0], ys[0], xs[1], ys[1], d.thickness, d.color);
            else if (d.cmd == CMD_RECT_FILL || d.cmd == CMD_QUAD_FILL)
                push_quad(xs, ys, d.color);
            else
                for (int i = 0; i < 4; i++)
                    push_line(xs[i], ys[i], xs[(i + 1) & 3], ys[(i + 1) & 3],
                              d.thickness, d.color);
            if (pending.size() > prior_size) pending[pending.size() - 1].last = 1'b1;
        endfunction

        function void check_res(geom_res_t a);
            geom_res_t e;
            if (pending.size() == 0)
            begin
                $error("unexpected result kind=%0d", a.kind);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (a.kind !== e.kind)
            begin
                $error("kind exp %0d got %0d", e.kind, a.kind);
                errors++;
            end
            if (a.vx !== e.vx)
            begin
                $error("vx exp %0d got %0d", e.vx, a.vx);
                errors++;
            end
            if (a.vy !== e.vy)
            begin
                $error("vy exp %0d got %0d", e.vy, a.vy);
                errors++;
            end
            if (a.vcolor !== e.vcolor)
            begin
                $error("vcolor exp %h got %h", e.vcolor, a.vcolor);
                errors++;
            end
            if (a.index_value !== e.index_value)
            begin
                $error("index_value exp %0d got %0d", e.index_value, a.index_value);
                errors++;
            end
            if (a.last !== e.last)
            begin
                $error("last exp %0d got %0d", e.last, a.last);
                errors++;
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    always #5 clk = ~clk;

    pqe_cmd_if cmd_ch();
    pqe_res_if res_ch();

    primitive_quad_expander i_dut (.clk(clk), .rst_n(rst_n), .cmd_ch(cmd_ch), .res_ch(res_ch));

    quad_scoreboard sb = new();
    bit  calm = 1'b0;
    longint cycles = 0;

    initial
    begin
        cmd_ch.valid = 1'b0;
        cmd_ch.cmd = '0;
        cmd_ch.p1_x = '0; cmd_ch.p1_y = '0; cmd_ch.p2_x = '0; cmd_ch.p2_y = '0;
        cmd_ch.p3_x = '0; cmd_ch.p3_y = '0; cmd_ch.p4_x = '0; cmd_ch.p4_y = '0;
        cmd_ch.color = '0;
        cmd_ch.thickness = '0;
        res_ch.ready = 1'b0;
    end

    // sink stalls in bursts
    initial
    begin
        int n;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (!calm && $urandom_range(0, 5) == 0)
            begin
                n = $urandom_range(1, 15);
                res_ch.ready <= 1'b0;
                repeat (n) @(posedge clk);
            end
            res_ch.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        geom_res_t a;
        cycles++;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            a = '{res_ch.kind, res_ch.vx, res_ch.vy, res_ch.vcolor, res_ch.index_value,
                  res_ch.last};
            sb.check_res(a);
        end
        if (cycles > 2000000)
        begin
            $display("tb NOT OK");
            $finish;
        end
    end

    // valid stays high between back-to-back requests and drops only for idling
    task automatic send_cmd(draw_cmd_t d);
        int n;
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            n = $urandom_range(1, 15);
            cmd_ch.valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
        cmd_ch.valid <= 1'b1;
        cmd_ch.cmd <= d.cmd;
        cmd_ch.p1_x <= d.px[0]; cmd_ch.p1_y <= d.py[0];
        cmd_ch.p2_x <= d.px[1]; cmd_ch.p2_y <= d.py[1];
        cmd_ch.p3_x <= d.px[2]; cmd_ch.p3_y <= d.py[2];
        cmd_ch.p4_x <= d.px[3]; cmd_ch.p4_y <= d.py[3];
        cmd_ch.color <= d.color;
        cmd_ch.thickness <= d.thickness;
        do @(posedge clk); while (!cmd_ch.ready);
        sb.note_cmd(d);
    endtask

    function automatic logic [15:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return 16'h7FFF;
            1: return 16'h8000;
            2: return 16'($urandom_range(0, 64)) - 16'd32;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic draw_cmd_t rand_cmd();
        draw_cmd_t d;
        d.cmd = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(5, 7)) : 3'($urandom_range(0, 4));
        for (int i = 0; i < 4; i++)
        begin
            d.px[i] = rand_coord();
            d.py[i] = rand_coord();
        end
        if ($urandom_range(0, 9) == 0) d.px[1] = d.px[0];
        if ($urandom_range(0, 9) == 0) d.py[1] = d.py[0];
        d.color = $urandom;
        if ($urandom_range(0, 12) == 0) d.color[31:24] = 8'd0;
        else if (d.color[31:24] == 0) d.color[31:24] = 8'hFF;
        case ($urandom_range(0, 4))
            0: d.thickness = 12'd0;
            1: d.thickness = 12'hFFF;
            default: d.thickness = 12'($urandom);
        endcase
        return d;
    endfunction

    function automatic draw_cmd_t mk(logic [2:0] c, int x1, int y1, int x2, int y2,
                                     logic [31:0] col, logic [11:0] t);
        draw_cmd_t d;
        d.cmd = c;
        d.px = '{16'(x1), 16'(x2), 16'sh7FFF, 16'sh8000};
        d.py = '{16'(y1), 16'(y2), 16'sh8000, 16'sh7FFF};
        d.color = col;
        d.thickness = t;
        return d;
    endfunction

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        send_cmd(mk(CMD_LINE, 0, 0, 160, 0, 32'hFF00_00FF, 12'd32));
        send_cmd(mk(CMD_LINE, 0, 0, 0, -160, 32'h0100_0000, 12'hFFF));
        send_cmd(mk(CMD_LINE, 16, 16, 16, 16, 32'hFFFF_FFFF, 12'd16));
        send_cmd(mk(CMD_LINE, -32768, -32768, 32767, 32767, 32'hFFFF_FFFF, 12'hFFF));
        send_cmd(mk(CMD_LINE, 32767, -32768, -32768, 32767, 32'h8000_0001, 12'd0));
        send_cmd(mk(CMD_LINE, 0, 0, 1, 0, 32'hFF00_0000, 12'hFFF));
        send_cmd(mk(CMD_LINE, 0, 0, 160, 0, 32'h00FF_FFFF, 12'd32));
        send_cmd(mk(CMD_RECT_LINE, 0, 0, 320, 160, 32'hFF12_3456, 12'd16));
        send_cmd(mk(CMD_RECT_LINE, 50, 50, 50, 50, 32'hFF12_3456, 12'd16));
        send_cmd(mk(CMD_RECT_LINE, 50, 0, 50, 100, 32'hFF12_3456, 12'd16));
        send_cmd(mk(CMD_RECT_LINE, -32768, -32768, 32767, 32767, 32'hFFFF_FFFF, 12'hFFF));
        send_cmd(mk(CMD_RECT_FILL, 10, 20, 30, 40, 32'h7F00_FF00, 12'd0));
        send_cmd(mk(CMD_RECT_FILL, 5, 5, 5, 5, 32'h7F00_FF00, 12'd0));
        send_cmd(mk(CMD_QUAD_LINE, 0, 0, 100, 0, 32'hFFAB_CDEF, 12'd24));
        send_cmd(mk(CMD_QUAD_FILL, 0, 0, 100, 0, 32'hFFAB_CDEF, 12'd24));
        send_cmd(mk(CMD_QUAD_FILL, 0, 0, 100, 0, 32'h0000_0000, 12'd24));
        send_cmd(mk(3'd5, 0, 0, 100, 0, 32'hFFFF_FFFF, 12'd24));
        send_cmd(mk(3'd7, 0, 0, 100, 0, 32'hFFFF_FFFF, 12'd24));
        // random commands, with no idling in the last stretch
        for (int i = 0; i < 460; i++)
        begin
            if (i >= 400) calm = 1'b1;
            send_cmd(rand_cmd());
        end
        cmd_ch.valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (600) @(posedge clk);
        if (sb.errors == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end
endmodule
